[sv/clfr_pkg.sv]
// ----------------------------------------------------------------------------
// clfr_pkg: shared types and constants of the CRLF line framer
// Character codes, input kind codes, the output queue size and the command
// struct that the front end hands to the back end.
// ----------------------------------------------------------------------------
package clfr_pkg;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	localparam logic [15:0] TIMEOUT_RESET = 16'd100;
	localparam logic [15:0] IDLE_MAX      = 16'hFFFF;
	localparam int          MIN_FRAME_FILL = 2;

	// Output queue between the line store readout and the result port.
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	// Store write and frame start, from the front end to the back end.
	typedef struct packed {
		logic       wr_en;
		logic [7:0] wr_data;
		logic       frame_go;
	} fe_cmd_t;

endpackage

[sv/clfr_front.sv]
// ----------------------------------------------------------------------------
// clfr_front: input side of the CRLF line framer
// Accepts bytes and ticks, keeps the idle counter and the fill count, writes
// bytes into the line store and starts a frame when a line ends in CR LF.
// ----------------------------------------------------------------------------
module clfr_front #(
	parameter int LINE_DEPTH = 64,
	localparam int AW = $clog2(LINE_DEPTH),
	localparam int FW = $clog2(LINE_DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic             kind,
	input  logic [7:0]       data_byte,
	input  logic             cfg_we,
	input  logic [15:0]      cfg_data,
	input  logic             busy,
	output clfr_pkg::fe_cmd_t cmd,
	output logic [AW-1:0]    wr_addr,
	output logic [FW-1:0]    frame_len
);
	import clfr_pkg::*;

	logic [15:0]   timeout_q;
	logic [15:0]   idle_q;
	logic [FW-1:0] fill_q;
	logic          prev_cr_q;

	logic          accept;
	logic          is_byte;
	logic          stale;
	logic [FW-1:0] fill_eff;
	logic [FW-1:0] fill_next;
	logic          at_cap;
	logic          store;
	logic          frame_done;

	always_comb begin
		full      = busy;
		accept    = push && !busy;
		is_byte   = (kind == KIND_BYTE);
		// A partial line that sat idle too long is dropped before this byte.
		stale     = (fill_q != '0) && (idle_q > timeout_q);
		fill_eff  = stale ? '0 : fill_q;
		fill_next = fill_eff + FW'(1);
		at_cap    = (fill_eff == FW'(LINE_DEPTH));
		store     = accept && is_byte && !at_cap;
		frame_done = store && (fill_eff >= FW'(MIN_FRAME_FILL)) && prev_cr_q
			&& (data_byte == CHAR_LF);

		cmd.wr_en    = store;
		cmd.wr_data  = data_byte;
		cmd.frame_go = frame_done;
		wr_addr      = fill_eff[AW-1:0];
		frame_len    = fill_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q    <= '0;
			fill_q    <= '0;
			prev_cr_q <= 1'b0;
		end else if (accept) begin
			if (!is_byte) begin
				if (idle_q != IDLE_MAX) begin
					idle_q <= idle_q + 16'd1;
				end
			end else begin
				idle_q <= '0;
				if (at_cap) begin
					fill_q <= '0;
				end else begin
					prev_cr_q <= (data_byte == CHAR_CR);
					fill_q    <= frame_done ? '0 : fill_next;
				end
			end
		end
	end

endmodule

[sv/clfr_back.sv]
// ----------------------------------------------------------------------------
// clfr_back: output side of the CRLF line framer
// Holds the line store, reads a finished line out one byte per cycle while
// the output queue has room, and queues the bytes for the result port.
// ----------------------------------------------------------------------------
module clfr_back #(
	parameter int LINE_DEPTH = 64,
	localparam int AW = $clog2(LINE_DEPTH),
	localparam int FW = $clog2(LINE_DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  clfr_pkg::fe_cmd_t cmd,
	input  logic [AW-1:0]     wr_addr,
	input  logic [FW-1:0]     frame_len,
	output logic              busy,
	output logic              empty,
	input  logic              pop,
	output logic [7:0]        line_byte,
	output logic              last
);
	import clfr_pkg::*;

	logic [7:0] line_mem [LINE_DEPTH];

	logic          busy_q;
	logic          issued_all_q;
	logic [AW-1:0] rd_idx_q;
	logic [FW-1:0] len_q;
	logic          vld_s1;
	logic          last_s1;
	logic [7:0]    rd_data_s1;

	logic [7:0]          oq_byte_q [OQ_DEPTH];
	logic                oq_last_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] oq_wr_q;
	logic [OQ_PTR_W-1:0] oq_rd_q;
	logic [OQ_CNT_W-1:0] oq_cnt_q;

	logic issue;
	logic last_issue;
	logic oq_pop;

	always_comb begin
		// One read may be in flight, so keep two free slots before issuing.
		issue      = busy_q && !issued_all_q && (oq_cnt_q <= OQ_CNT_W'(OQ_DEPTH - 2));
		last_issue = ((FW'(rd_idx_q) + FW'(1)) == len_q);
		busy       = busy_q;
		empty      = (oq_cnt_q == '0);
		oq_pop     = pop && !empty;
		line_byte  = oq_byte_q[oq_rd_q];
		last       = oq_last_q[oq_rd_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			line_mem[wr_addr] <= cmd.wr_data;
		end
		if (issue) begin
			rd_data_s1 <= line_mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			issued_all_q <= 1'b0;
			rd_idx_q     <= '0;
			len_q        <= '0;
			vld_s1       <= 1'b0;
			last_s1      <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if (issue) begin
				last_s1  <= last_issue;
				rd_idx_q <= rd_idx_q + AW'(1);
				if (last_issue) begin
					issued_all_q <= 1'b1;
				end
			end
			if (vld_s1 && last_s1) begin
				busy_q <= 1'b0;
			end
			if (cmd.frame_go) begin
				busy_q       <= 1'b1;
				issued_all_q <= 1'b0;
				rd_idx_q     <= '0;
				len_q        <= frame_len;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			oq_byte_q[oq_wr_q] <= rd_data_s1;
			oq_last_q[oq_wr_q] <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (vld_s1) begin
				oq_wr_q <= oq_wr_q + OQ_PTR_W'(1);
			end
			if (oq_pop) begin
				oq_rd_q <= oq_rd_q + OQ_PTR_W'(1);
			end
			if (vld_s1 && !oq_pop) begin
				oq_cnt_q <= oq_cnt_q + OQ_CNT_W'(1);
			end else if (!vld_s1 && oq_pop) begin
				oq_cnt_q <= oq_cnt_q - OQ_CNT_W'(1);
			end
		end
	end

endmodule

[sv/crlf_line_framer_with_timeout.sv]
// ----------------------------------------------------------------------------
// crlf_line_framer_with_timeout: CRLF line framer with inter-byte timeout
// Collects received bytes into lines and emits each line that ends in CR LF
// byte by byte, discarding partial lines that go idle for too long.
// ----------------------------------------------------------------------------
//
//  Channel   | Direction | Handshake        | Payload
//  ----------+-----------+------------------+-------------------------------
//  input     | in        | push / full      | kind, data_byte
//  result    | out       | empty / pop      | line_byte, last
//  config    | in        | cfg_we           | cfg_data (timeout_ticks)
//
// A byte or a tick is taken in every cycle while full is low. A byte that
// completes a line (at least three bytes, ending in CR LF) raises full while
// the single read port of the line store reads it out, one byte per cycle,
// into a four-entry output queue. A stall on pop holds the readout, and so
// full, once that queue fills. The line store needs no clearing pass; reset
// only loads the default timeout and clears the fill count, the CR flag, the
// idle counter, the readout control and the queue pointers.
//
module crlf_line_framer_with_timeout #(
	parameter int LINE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input transaction: push while full is low.
	input  logic        push,
	output logic        full,
	input  logic        kind,
	input  logic [7:0]  data_byte,
	// Result transaction: pop while empty is low.
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  line_byte,
	output logic        last,
	// Timeout register write: user writes only while block is idle; unenforced.
	input  logic        cfg_we,
	input  logic [15:0] cfg_data
);
	import clfr_pkg::*;

	localparam int AW = $clog2(LINE_DEPTH);
	localparam int FW = $clog2(LINE_DEPTH + 1);

	// The front end classifies each transaction: ticks advance the idle
	// counter, bytes go into the line store, and a byte that closes a line
	// hands the line length to the back end.
	fe_cmd_t       cmd;
	logic [AW-1:0] wr_addr;
	logic [FW-1:0] frame_len;
	logic          busy;

	clfr_front #(
		.LINE_DEPTH(LINE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.kind      (kind),
		.data_byte (data_byte),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.busy      (busy),
		.cmd       (cmd),
		.wr_addr   (wr_addr),
		.frame_len (frame_len)
	);

	// The back end owns the line store. While it reads a finished line out,
	// it reports busy and the front end holds off new transactions, so the
	// next line cannot overwrite bytes that are still to be sent.
	clfr_back #(
		.LINE_DEPTH(LINE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.wr_addr   (wr_addr),
		.frame_len (frame_len),
		.busy      (busy),
		.empty     (empty),
		.pop       (pop),
		.line_byte (line_byte),
		.last      (last)
	);

endmodule

[sv/clfr_checker.sv]
// ----------------------------------------------------------------------------
// clfr_checker: port-level checks for the CRLF line framer
// Watches the top-level ports and flags results or stalls that no line
// ending could have caused.
// ----------------------------------------------------------------------------
module clfr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        kind,
	input logic [7:0]  data_byte,
	input logic        empty,
	input logic        pop,
	input logic [7:0]  line_byte,
	input logic        last,
	input logic        cfg_we,
	input logic [15:0] cfg_data
);
	import clfr_pkg::*;

	logic in_take;
	logic lf_take;

	assign in_take = push && !full;
	assign lf_take = in_take && (kind == KIND_BYTE) && (data_byte == CHAR_LF);

	// Once reset has been seen at an edge, nothing is queued at the next one.
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> empty)
		else $error("result queue not empty in reset");

	// Only a line feed can start a readout and stall the input.
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && !lf_take |=> !full)
		else $error("input stalled without a completed line");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(lf_take))
		else $error("full rose without a line feed");

	// With no readout running, results only appear after a line feed.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		empty && !full && !lf_take |=> empty)
		else $error("result appeared without a completed line");

endmodule

bind crlf_line_framer_with_timeout clfr_checker u_clfr_checker (.*);

[dv/line_frame_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_frame_checker: predicts and checks the output of the CRLF line framer
// Watches the input, result and timeout register ports, keeps its own copy
// of the line store, and compares every popped byte with the oldest one owed.
// ----------------------------------------------------------------------------
module line_frame_checker
	import clfr_pkg::*;
#(
	parameter int LINE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic        kind,
	input  logic [7:0]  data_byte,
	input  logic        empty,
	input  logic        pop,
	input  logic [7:0]  line_byte,
	input  logic        last,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	output int          mismatch_count,
	output int          bytes_owed
);

	typedef struct {
		logic [7:0] value;
		logic       is_last;
	} frame_byte_t;

	frame_byte_t owed_bytes[$];
	logic [7:0]  line_copy [LINE_DEPTH];
	int unsigned fill_level;
	logic [15:0] idle_count;
	logic [15:0] timeout_setting;

	initial begin
		mismatch_count = 0;
		bytes_owed = 0;
	end

	// Only the first few mismatches are printed, but all are counted.
	task automatic report_mismatch(input string msg);
		if (mismatch_count < 40) begin
			$display("%0t ns: mismatch: %s", $time, msg);
		end
		mismatch_count++;
	endtask

	// Applies one accepted input transaction to the local copy of the framer.
	task automatic frame_input(input logic item_kind, input logic [7:0] item_byte);
		int unsigned i;
		if (item_kind == KIND_TICK) begin
			if (idle_count != IDLE_MAX) begin
				idle_count++;
			end
			return;
		end
		if (fill_level > 0 && idle_count > timeout_setting) begin
			fill_level = 0;
		end
		idle_count = '0;
		if (fill_level >= LINE_DEPTH) begin
			fill_level = 0;
			return;
		end
		line_copy[fill_level] = item_byte;
		fill_level++;
		if (fill_level > MIN_FRAME_FILL && line_copy[fill_level - 2] == CHAR_CR &&
				line_copy[fill_level - 1] == CHAR_LF) begin
			for (i = 0; i < fill_level; i++) begin
				owed_bytes.push_back('{line_copy[i], i + 1 == fill_level});
			end
			fill_level = 0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		frame_byte_t oldest;
		if (!arst_n) begin
			fill_level = 0;
			idle_count = '0;
			timeout_setting = TIMEOUT_RESET;
			owed_bytes.delete();
		end else begin
			if (cfg_we) begin
				timeout_setting = cfg_data;
			end
			if (push && !full) begin
				frame_input(kind, data_byte);
			end
			if (pop && !empty) begin
				if (owed_bytes.size() == 0) begin
					report_mismatch($sformatf("line byte %02h (last %b) with none owed",
						line_byte, last));
				end else begin
					oldest = owed_bytes.pop_front();
					if (line_byte !== oldest.value) begin
						report_mismatch($sformatf("line_byte expected %02h, got %02h",
							oldest.value, line_byte));
					end
					if (last !== oldest.is_last) begin
						report_mismatch($sformatf("last expected %b, got %b on byte %02h",
							oldest.is_last, last, oldest.value));
					end
				end
			end
		end
		bytes_owed = owed_bytes.size();
	end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: top level of the CRLF line framer verification
// Drives bytes and ticks through the push/full port, pops results with
// random back-pressure, sweeps the timeout register, and gives the verdict
// from the mismatch count of the line frame checker.
// ----------------------------------------------------------------------------
module testbench;
	import clfr_pkg::*;

	localparam int LINE_DEPTH      = 64;
	// Long enough for the output queue to fill and the input to stall.
	localparam int HOLD_OFF_CYCLES = 400;
	// Cycles allowed after the last owed byte for a readout still in flight.
	localparam int SETTLE_CYCLES   = 8;
	// Each random segment sends roughly this many input transactions.
	localparam int SEGMENT_ITEMS   = 10;
	localparam int RUN_LIMIT_NS    = 10_000_000;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic        kind;
	logic [7:0]  data_byte;
	logic        empty;
	logic        pop;
	logic [7:0]  line_byte;
	logic        last;
	logic        cfg_we;
	logic [15:0] cfg_data;

	int          mismatch_count;
	int          bytes_owed;

	// Percentages of cycles in which each side idles, set per phase.
	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	// Raised by the stimulus to make the receiver stop popping for a while.
	logic        hold_off_request = 1'b0;
	// Mirror of the timeout register, used to shape stale-line sequences.
	logic [15:0] timeout_now = TIMEOUT_RESET;
	int          items_sent = 0;

	crlf_line_framer_with_timeout #(
		.LINE_DEPTH(LINE_DEPTH)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.kind     (kind),
		.data_byte(data_byte),
		.empty    (empty),
		.pop      (pop),
		.line_byte(line_byte),
		.last     (last),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	line_frame_checker #(
		.LINE_DEPTH(LINE_DEPTH)
	) checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.kind          (kind),
		.data_byte     (data_byte),
		.empty         (empty),
		.pop           (pop),
		.line_byte     (line_byte),
		.last          (last),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.mismatch_count(mismatch_count),
		.bytes_owed    (bytes_owed)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Hard stop in case the block hangs or never drains its output.
	initial begin
		#RUN_LIMIT_NS;
		$display("** crlf_line_framer_with_timeout: FAILED **");
		$finish;
	end

	// The receiver. Outside a hold-off it pops at random according to the
	// current idle percentage. A hold-off is counted here, independently of
	// the stimulus, so the sender keeps offering transactions meanwhile.
	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_request) begin
				pop <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off_request = 1'b0;
			end
			pop <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Offers one input transaction and returns at a falling edge after it
	// was taken and any idle cycles, which carry random junk on the payload.
	task automatic send_item(input logic item_kind, input logic [7:0] item_byte);
		push      <= 1'b1;
		kind      <= item_kind;
		data_byte <= item_byte;
		@(posedge clk);
		while (full) @(posedge clk);
		items_sent++;
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			push      <= 1'b0;
			kind      <= 1'($urandom_range(1));
			data_byte <= 8'($urandom_range(255));
			@(negedge clk);
		end
	endtask

	task automatic send_ticks(input int count);
		repeat (count) send_item(KIND_TICK, 8'($urandom_range(255)));
	endtask

	// Sends a line of len bytes whose last two are CR LF. The body is either
	// printable text, which cannot hold a CR LF of its own, or any byte at all.
	// Ticks are sprinkled between bytes, now and then enough to go stale.
	task automatic send_line(input int len, input bit printable);
		int i;
		logic [7:0] b;
		for (i = 0; i < len; i++) begin
			if (i > 0 && $urandom_range(99) < 12) begin
				send_ticks($urandom_range(1, 3));
			end
			if (i > 0 && timeout_now < 16 && $urandom_range(99) < 4) begin
				send_ticks(timeout_now + 1);
			end
			if (i == len - 2) begin
				b = CHAR_CR;
			end else if (i == len - 1) begin
				b = CHAR_LF;
			end else if (printable) begin
				b = 8'($urandom_range(8'h7E, 8'h20));
			end else begin
				b = 8'($urandom_range(255));
			end
			send_item(KIND_BYTE, b);
		end
	endtask

	// Most lines are short; a few reach the full depth of the line store.
	function automatic int pick_line_len();
		if ($urandom_range(11) == 0) begin
			return $urandom_range(64, 13);
		end
		return $urandom_range(12, 3);
	endfunction

	// Mostly complete lines with random content, the rest noise, partial
	// lines left to go stale, and bare CR LF pairs that the next line extends.
	task automatic run_traffic(input int count);
		int start;
		int pick;
		start = items_sent;
		while (items_sent - start < count) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				send_line(pick_line_len(), 1'($urandom_range(1)));
			end else if (pick < 80) begin
				repeat ($urandom_range(4, 1))
					send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
			end else if (pick < 92) begin
				repeat ($urandom_range(5, 1)) send_item(KIND_BYTE, 8'($urandom_range(255)));
				if (timeout_now < 16) begin
					send_ticks(timeout_now + 1 + $urandom_range(2));
				end else begin
					send_ticks($urandom_range(3, 1));
				end
			end else begin
				send_item(KIND_BYTE, CHAR_CR);
				send_item(KIND_BYTE, CHAR_LF);
				send_line(pick_line_len(), 1'b1);
			end
		end
	endtask

	// Stops offering and waits until every owed result has been popped, plus
	// a few cycles for work that produces no result.
	task automatic wait_drained();
		push <= 1'b0;
		@(negedge clk);
		while (bytes_owed != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Register writes happen only while the block is idle.
	task automatic write_timeout(input logic [15:0] value);
		cfg_we      <= 1'b1;
		cfg_data    <= value;
		timeout_now = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	int          phase;
	int          seg;
	logic [15:0] timeout_plan [6];
	int          tx_plan [3] = '{22, 65, 0};
	int          rx_plan [3] = '{65, 22, 0};

	initial begin
		arst_n    = 1'b0;
		push      = 1'b0;
		kind      = KIND_BYTE;
		data_byte = 8'h00;
		cfg_we    = 1'b0;
		cfg_data  = 16'h0000;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, with a timeout of one so that stale lines take
		// only a couple of ticks.
		write_timeout(16'd1);
		// Extreme byte values in a short frame.
		send_item(KIND_BYTE, 8'h00);
		send_item(KIND_BYTE, 8'hFF);
		send_item(KIND_BYTE, CHAR_CR);
		send_item(KIND_BYTE, CHAR_LF);
		// A bare CR LF is kept and extended by the next line.
		send_item(KIND_BYTE, CHAR_CR);
		send_item(KIND_BYTE, CHAR_LF);
		send_item(KIND_BYTE, 8'h55);
		send_item(KIND_BYTE, CHAR_CR);
		send_item(KIND_BYTE, CHAR_LF);
		// Two idle ticks exceed the timeout, so the partial line is dropped.
		send_item(KIND_BYTE, 8'h41);
		send_item(KIND_TICK, 8'hFF);
		send_item(KIND_TICK, 8'h00);
		send_item(KIND_BYTE, 8'h42);
		send_item(KIND_BYTE, CHAR_CR);
		send_item(KIND_BYTE, CHAR_LF);
		// One tick equals the timeout and the line survives.
		send_item(KIND_BYTE, 8'h43);
		send_item(KIND_TICK, 8'h00);
		send_item(KIND_BYTE, 8'h44);
		send_item(KIND_BYTE, CHAR_CR);
		send_item(KIND_BYTE, CHAR_LF);
		// CR LF CR LF: the first pair is bare, the second ends the frame.
		send_item(KIND_BYTE, CHAR_CR);
		send_item(KIND_BYTE, CHAR_LF);
		send_item(KIND_BYTE, CHAR_CR);
		send_item(KIND_BYTE, CHAR_LF);

		// Random part: three idle phases, two timeout settings each. A zero
		// timeout drops any partial line that sees a single tick.
		timeout_plan = '{16'd0, 16'd3, 16'hFFFF, 16'd0, 16'd1, TIMEOUT_RESET};
		timeout_plan[3] = 16'($urandom_range(9, 2));
		for (phase = 0; phase < 3; phase++) begin
			tx_idle_pct = tx_plan[phase];
			rx_idle_pct = rx_plan[phase];
			for (seg = 0; seg < 2; seg++) begin
				wait_drained();
				write_timeout(timeout_plan[phase * 2 + seg]);
				if (phase == 2 && seg == 0) begin
					// The receiver stops while full lines keep coming, so the
					// output queue fills and the input stalls.
					hold_off_request = 1'b1;
					@(negedge clk);
					repeat (3) send_line(12, 1'b1);
				end
				run_traffic(SEGMENT_ITEMS);
			end
		end

		// Store full: 64 bytes with no line end, then one byte that is
		// dropped and clears the store, then a short line.
		wait_drained();
		write_timeout(16'hFFFF);
		repeat (LINE_DEPTH) send_item(KIND_BYTE, 8'($urandom_range(8'h7E, 8'h20)));
		send_item(KIND_BYTE, 8'($urandom_range(255)));
		send_line(4, 1'b1);
		// A line that fills the store exactly.
		send_line(LINE_DEPTH, 1'b1);

		wait_drained();
		repeat (20) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("** crlf_line_framer_with_timeout: PASSED **");
		end else begin
			$display("** crlf_line_framer_with_timeout: FAILED **");
		end
		$finish;
	end

endmodule
